// File: rtl/trcp_pkg.sv
// Shared types, widths and register codes for the triangle rotate/cull/project block.
`default_nettype none

package trcp_pkg;

   localparam int COORD_W         = 32;
   localparam int COORD_FRAC_BITS = 16;
   localparam int TRIG_W          = 16;
   localparam int TRIG_FRAC_BITS  = 14;
   localparam int DIM_W           = 12;
   localparam int COLOR_W         = 24;
   localparam int SCR_W           = 16;
   localparam int NUM_V           = 3;
   localparam int VIDX_W          = $clog2(NUM_V);
   localparam int CSR_IDX_W       = 3;

   localparam int ROT_STAGES      = 3;
   localparam int MERGE_STAGES    = 2;
   localparam int FRONT_STAGES    = ROT_STAGES + MERGE_STAGES;

   // projection arithmetic
   localparam int FOCAL_W   = DIM_W + 1;
   localparam int CTR_W     = DIM_W - 1;
   localparam int NUM_W     = COORD_W + FOCAL_W + 1;
   localparam int N_W       = NUM_W + 2;
   localparam int MAG_W     = COORD_W + SCR_W - 1;
   localparam int DIV_STEPS = SCR_W;

   localparam int IN_W  = 3 * NUM_V * COORD_W + COLOR_W;
   localparam int OUT_W = 4 * COORD_W + 2 * SCR_W + COLOR_W;

   localparam logic [COORD_W-1:0] Z_ONE = COORD_W'(1) << COORD_FRAC_BITS;
   localparam logic [VIDX_W-1:0]  LAST_V = VIDX_W'(NUM_V - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS_PITCH,
      REG_SIN_PITCH,
      REG_COS_YAW,
      REG_SIN_YAW,
      REG_COS_ROLL,
      REG_SIN_ROLL,
      REG_SCREEN_WIDTH,
      REG_SCREEN_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_pitch;
      logic signed [TRIG_W-1:0] sin_pitch;
      logic signed [TRIG_W-1:0] cos_yaw;
      logic signed [TRIG_W-1:0] sin_yaw;
      logic signed [TRIG_W-1:0] cos_roll;
      logic signed [TRIG_W-1:0] sin_roll;
      logic [DIM_W-1:0]         screen_w;
      logic [DIM_W-1:0]         screen_h;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   typedef vertex_type [NUM_V-1:0] tri_type;

   typedef struct packed {
      vertex_type                vtx;
      logic                      vis;
      logic signed [COORD_W-1:0] depth;
      logic [COLOR_W-1:0]        color;
      logic                      last;
   } carry_type;

   typedef struct packed {
      vertex_type                vtx;
      logic signed [SCR_W-1:0]   sx;
      logic signed [SCR_W-1:0]   sy;
      logic                      vis;
      logic signed [COORD_W-1:0] depth;
      logic [COLOR_W-1:0]        color;
      logic                      last;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: rtl/trcp_lane.sv
// One rotation lane: pitch, yaw and roll, one registered stage each.
`default_nettype none

module trcp_lane import trcp_pkg::*; (
   input  wire                        clock,
   input  wire  [ROT_STAGES-1:0]      ld,
   input  cfg_type                    cfg,
   input  vertex_type                 vin,
   output vertex_type                 vout
);

   localparam int PROD_W = COORD_W + TRIG_W;
   localparam int ACC_W  = PROD_W + 1;

   // p*a - q*b or p*a + q*b, floor shift, saturate to 32 bits
   function automatic logic signed [COORD_W-1:0] rot_mix(
      input logic signed [COORD_W-1:0] p,
      input logic signed [TRIG_W-1:0]  a,
      input logic signed [COORD_W-1:0] q,
      input logic signed [TRIG_W-1:0]  b,
      input logic                      sub
   );
      logic signed [PROD_W-1:0] pa;
      logic signed [PROD_W-1:0] qb;
      logic signed [ACC_W-1:0]  acc;
      logic signed [ACC_W-1:0]  sh;
      logic [ACC_W-COORD_W:0]   top;
      logic signed [COORD_W-1:0] res;
      pa  = PROD_W'(p) * PROD_W'(a);
      qb  = PROD_W'(q) * PROD_W'(b);
      acc = sub ? (ACC_W'(pa) - ACC_W'(qb)) : (ACC_W'(pa) + ACC_W'(qb));
      sh  = acc >>> TRIG_FRAC_BITS;
      top = sh[ACC_W-1:COORD_W-1];
      if (&top || ~|top) begin
         res = sh[COORD_W-1:0];
      end else if (sh[ACC_W-1]) begin
         res = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return res;
   endfunction

   vertex_type s0_ff, s0_in;
   vertex_type s1_ff, s1_in;
   vertex_type s2_ff, s2_in;

   always_comb begin
      // about x
      s0_in.x = vin.x;
      s0_in.y = rot_mix(vin.y, cfg.cos_pitch, vin.z, cfg.sin_pitch, 1'b1);
      s0_in.z = rot_mix(vin.y, cfg.sin_pitch, vin.z, cfg.cos_pitch, 1'b0);
      // about z
      s1_in.x = rot_mix(s0_ff.x, cfg.cos_yaw, s0_ff.y, cfg.sin_yaw, 1'b1);
      s1_in.y = rot_mix(s0_ff.x, cfg.sin_yaw, s0_ff.y, cfg.cos_yaw, 1'b0);
      s1_in.z = s0_ff.z;
      // about y
      s2_in.x = rot_mix(s1_ff.x, cfg.cos_roll, s1_ff.z, cfg.sin_roll, 1'b1);
      s2_in.y = s1_ff.y;
      s2_in.z = rot_mix(s1_ff.x, cfg.sin_roll, s1_ff.z, cfg.cos_roll, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (ld[0]) s0_ff <= s0_in;
      if (ld[1]) s1_ff <= s1_in;
      if (ld[2]) s2_ff <= s2_in;
   end

   assign vout = s2_ff;

endmodule

`default_nettype wire

// File: rtl/trcp_merge.sv
// Merges the three lanes: backface cross product, near-side test, minimum z.
`default_nettype none

module trcp_merge import trcp_pkg::*; (
   input  wire                        clock,
   input  wire  [MERGE_STAGES-1:0]    ld,
   input  tri_type                    tin,
   output tri_type                    tout,
   output logic                       vis,
   output logic signed [COORD_W-1:0]  depth
);

   localparam int D_W  = COORD_W + 1;
   localparam int CR_W = 2 * D_W;

   logic signed [D_W-1:0]     dx1, dx2, dy1, dy2;
   logic signed [CR_W-1:0]    pa_in, pb_in, pa_ff, pb_ff;
   logic signed [COORD_W-1:0] z0, z1, z2, zmin_in, zmin_ff;
   logic                      near_in, near_ff;
   tri_type                   m0_tri_ff, m1_tri_ff;
   logic                      vis_ff;
   logic signed [COORD_W-1:0] depth_ff;

   always_comb begin
      dx1   = D_W'(tin[0].x) - D_W'(tin[1].x);
      dx2   = D_W'(tin[0].x) - D_W'(tin[2].x);
      dy1   = D_W'(tin[0].y) - D_W'(tin[1].y);
      dy2   = D_W'(tin[0].y) - D_W'(tin[2].y);
      pa_in = CR_W'(dx1) * CR_W'(dy2);
      pb_in = CR_W'(dy1) * CR_W'(dx2);
      z0    = tin[0].z;
      z1    = tin[1].z;
      z2    = tin[2].z;
      near_in = z0[COORD_W-1] | z1[COORD_W-1] | z2[COORD_W-1];
      zmin_in = z0;
      if (z1 < zmin_in) zmin_in = z1;
      if (z2 < zmin_in) zmin_in = z2;
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         near_ff   <= near_in;
         zmin_ff   <= zmin_in;
         m0_tri_ff <= tin;
      end
      if (ld[1]) begin
         vis_ff    <= near_ff && (pa_ff < pb_ff);
         depth_ff  <= zmin_ff;
         m1_tri_ff <= m0_tri_ff;
      end
   end

   assign tout  = m1_tri_ff;
   assign vis   = vis_ff;
   assign depth = depth_ff;

endmodule

`default_nettype wire

// File: rtl/trcp_proj.sv
// Perspective projection, a vertex per cycle if adv: scale, offset, piped divide, saturate.
`default_nettype none

module trcp_proj import trcp_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           adv,
   input  wire           in_valid,
   input  carry_type     in_item,
   input  cfg_type       cfg,
   output logic          out_valid,
   output rsp_item_type  out_item
);

   localparam int CP_W = CTR_W + COORD_W;
   localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};
   localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};

   function automatic logic signed [SCR_W-1:0] fmt(input logic neg,
                                                   input logic [SCR_W-1:0] q);
      logic signed [SCR_W-1:0] r;
      if (q[SCR_W-1]) begin
         r = neg ? SCR_MIN : SCR_MAX;
      end else begin
         r = neg ? -$signed(q) : $signed(q);
      end
      return r;
   endfunction

   // stage P0: numerators and |z|
   logic [FOCAL_W-1:0]       focal;
   logic signed [NUM_W-1:0]  numx_in, numy_in, numx_ff, numy_ff;
   logic [COORD_W-1:0]       zmag, zabs_in, zabs_ff;
   logic                     p0_v_ff;
   carry_type                p0_item_ff;

   always_comb begin
      focal   = {cfg.screen_w, 1'b0};
      numx_in = NUM_W'(in_item.vtx.x) * NUM_W'($signed({1'b0, focal}));
      numy_in = -(NUM_W'(in_item.vtx.y) * NUM_W'($signed({1'b0, focal})));
      zmag    = in_item.vtx.z[COORD_W-1] ? (~in_item.vtx.z + 1'b1) : in_item.vtx.z;
      zabs_in = (zmag < Z_ONE) ? Z_ONE : zmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
      end else if (adv) begin
         p0_v_ff <= in_valid;
      end
      if (adv) begin
         p0_item_ff <= in_item;
         numx_ff    <= numx_in;
         numy_ff    <= numy_in;
         zabs_ff    <= zabs_in;
      end
   end

   // stage P1 feeds divider slot 0: add centre*|z|, split sign and magnitude
   logic [CP_W-1:0]          cpx, cpy;
   logic signed [N_W-1:0]    nx, ny;

   logic                     dv_v_ff    [DIV_STEPS+1];
   carry_type                dv_item_ff [DIV_STEPS+1];
   logic [COORD_W-1:0]       dv_zabs_ff [DIV_STEPS+1];
   logic [MAG_W-1:0]         dv_remx_ff [DIV_STEPS+1];
   logic [MAG_W-1:0]         dv_remy_ff [DIV_STEPS+1];
   logic [SCR_W-1:0]         dv_qx_ff   [DIV_STEPS+1];
   logic [SCR_W-1:0]         dv_qy_ff   [DIV_STEPS+1];
   logic                     dv_negx_ff [DIV_STEPS+1];
   logic                     dv_negy_ff [DIV_STEPS+1];

   always_comb begin
      cpx = CP_W'(cfg.screen_w[DIM_W-1:1]) * CP_W'(zabs_ff);
      cpy = CP_W'(cfg.screen_h[DIM_W-1:1]) * CP_W'(zabs_ff);
      nx  = N_W'(numx_ff) + N_W'($signed({1'b0, cpx}));
      ny  = N_W'(numy_ff) + N_W'($signed({1'b0, cpy}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= p0_v_ff;
      end
      if (adv) begin
         dv_item_ff[0] <= p0_item_ff;
         dv_zabs_ff[0] <= zabs_ff;
         dv_negx_ff[0] <= nx[N_W-1];
         dv_negy_ff[0] <= ny[N_W-1];
         dv_remx_ff[0] <= nx[N_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
         dv_remy_ff[0] <= ny[N_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
      end
   end

   // restoring divide, one quotient bit per stage; the top bit flags overflow
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      localparam int SH = DIV_STEPS - k;
      logic [MAG_W-1:0] dvs;
      logic             gex, gey;

      assign dvs = MAG_W'(dv_zabs_ff[k-1]) << SH;
      assign gex = dv_remx_ff[k-1] >= dvs;
      assign gey = dv_remy_ff[k-1] >= dvs;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
         if (adv) begin
            dv_item_ff[k] <= dv_item_ff[k-1];
            dv_zabs_ff[k] <= dv_zabs_ff[k-1];
            dv_negx_ff[k] <= dv_negx_ff[k-1];
            dv_negy_ff[k] <= dv_negy_ff[k-1];
            dv_remx_ff[k] <= gex ? (dv_remx_ff[k-1] - dvs) : dv_remx_ff[k-1];
            dv_remy_ff[k] <= gey ? (dv_remy_ff[k-1] - dvs) : dv_remy_ff[k-1];
            dv_qx_ff[k]   <= dv_qx_ff[k-1] | (SCR_W'(gex) << SH);
            dv_qy_ff[k]   <= dv_qy_ff[k-1] | (SCR_W'(gey) << SH);
         end
      end
   end

   // output register
   logic         out_v_ff;
   rsp_item_type out_ff, out_in;

   always_comb begin
      out_in.vtx   = dv_item_ff[DIV_STEPS].vtx;
      out_in.sx    = fmt(dv_negx_ff[DIV_STEPS], dv_qx_ff[DIV_STEPS]);
      out_in.sy    = fmt(dv_negy_ff[DIV_STEPS], dv_qy_ff[DIV_STEPS]);
      out_in.vis   = dv_item_ff[DIV_STEPS].vis;
      out_in.depth = dv_item_ff[DIV_STEPS].depth;
      out_in.color = dv_item_ff[DIV_STEPS].color;
      out_in.last  = dv_item_ff[DIV_STEPS].last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[DIV_STEPS];
      end
      if (adv) out_ff <= out_in;
   end

   assign out_valid = out_v_ff;
   assign out_item  = out_ff;

endmodule

`default_nettype wire

// File: rtl/triangle_rotate_cull_project_top.sv
// Top level: triangle rotate, backface cull and perspective projection.
// A triangle request carries three Q16.16 vertices and a colour. Three rotation
// lanes turn the vertices in parallel (pitch about x, yaw about z, roll about y,
// one stage each), the merge forms the backface cross product, the near-side
// test and the minimum z, and a serializer hands the vertices one per cycle,
// when not stalled, to the single projection pipeline with a 16-stage restoring
// divider for x and y. The block can take a new triangle before the last one's
// results are out and sends a triangle's three results in order, the third with
// tlast. A result passes the lane, merge and serializer registers, stage P0,
// divider slot 0, the divider steps and the output register. rsp_tready low
// stalls the serializer and projection pipe; the front stages keep taking
// requests until they fill. Registers are to be written through the csr port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module triangle_rotate_cull_project_top import trcp_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   // request: a_x a_y a_z b_x b_y b_z c_x c_y c_z (32 each), color_rgb (24)
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [IN_W-1:0]        req_tdata,
   // response: rot_x rot_y rot_z (32 each), screen_x screen_y (16 each),
   //           depth_key (32), color_out (24)
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [OUT_W-1:0]       rsp_tdata,
   // response user: visible
   output logic [0:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [TRIG_W-1:0]      csr_data
);

   // ---------------- configuration registers
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_COS_PITCH:     cfg_in.cos_pitch = csr_data;
            REG_SIN_PITCH:     cfg_in.sin_pitch = csr_data;
            REG_COS_YAW:       cfg_in.cos_yaw   = csr_data;
            REG_SIN_YAW:       cfg_in.sin_yaw   = csr_data;
            REG_COS_ROLL:      cfg_in.cos_roll  = csr_data;
            REG_SIN_ROLL:      cfg_in.sin_roll  = csr_data;
            REG_SCREEN_WIDTH:  cfg_in.screen_w  = csr_data[DIM_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_h  = csr_data[DIM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_pitch <= TRIG_W'(16384);
         cfg_ff.sin_pitch <= '0;
         cfg_ff.cos_yaw   <= TRIG_W'(16384);
         cfg_ff.sin_yaw   <= '0;
         cfg_ff.cos_roll  <= TRIG_W'(16384);
         cfg_ff.sin_roll  <= '0;
         cfg_ff.screen_w  <= DIM_W'(640);
         cfg_ff.screen_h  <= DIM_W'(480);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // ---------------- front: lanes + merge, elastic per stage
   logic [FRONT_STAGES-1:0] f_v_ff;
   logic [FRONT_STAGES-1:0] f_rdy;
   logic                    sr_take;
   logic                    b_adv;
   logic [COLOR_W-1:0]      color_ff [FRONT_STAGES];

   always_comb begin
      f_rdy[FRONT_STAGES-1] = !f_v_ff[FRONT_STAGES-1] || sr_take;
      for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
         f_rdy[k] = !f_v_ff[k] || f_rdy[k+1];
      end
   end

   assign req_tready = f_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= '0;
      end else begin
         if (f_rdy[0]) f_v_ff[0] <= req_tvalid;
         for (int k = 1; k < FRONT_STAGES; k++) begin
            if (f_rdy[k]) f_v_ff[k] <= f_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (f_rdy[0]) color_ff[0] <= req_tdata[IN_W-1 -: COLOR_W];
      for (int k = 1; k < FRONT_STAGES; k++) begin
         if (f_rdy[k]) color_ff[k] <= color_ff[k-1];
      end
   end

   tri_type in_tri, rot_tri, mrg_tri;

   for (genvar v = 0; v < NUM_V; v++) begin : g_lane
      assign in_tri[v].x = req_tdata[(3*v)*COORD_W   +: COORD_W];
      assign in_tri[v].y = req_tdata[(3*v+1)*COORD_W +: COORD_W];
      assign in_tri[v].z = req_tdata[(3*v+2)*COORD_W +: COORD_W];

      trcp_lane u_lane (
         .clock (clock),
         .ld    (f_rdy[ROT_STAGES-1:0]),
         .cfg   (cfg_ff),
         .vin   (in_tri[v]),
         .vout  (rot_tri[v])
      );
   end

   logic                      mrg_vis;
   logic signed [COORD_W-1:0] mrg_depth;

   trcp_merge u_merge (
      .clock (clock),
      .ld    (f_rdy[FRONT_STAGES-1:ROT_STAGES]),
      .tin   (rot_tri),
      .tout  (mrg_tri),
      .vis   (mrg_vis),
      .depth (mrg_depth)
   );

   // ---------------- serializer: one vertex per cycle into projection
   logic                      sr_v_ff;
   logic [VIDX_W-1:0]         sr_cnt_ff;
   tri_type                   sr_tri_ff;
   logic                      sr_vis_ff;
   logic signed [COORD_W-1:0] sr_depth_ff;
   logic [COLOR_W-1:0]        sr_color_ff;

   assign b_adv   = !rsp_tvalid || rsp_tready;
   assign sr_take = !sr_v_ff || (sr_cnt_ff == LAST_V && b_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_v_ff   <= 1'b0;
         sr_cnt_ff <= '0;
      end else if (sr_take) begin
         sr_v_ff   <= f_v_ff[FRONT_STAGES-1];
         sr_cnt_ff <= '0;
      end else if (b_adv) begin
         sr_cnt_ff <= sr_cnt_ff + 1'b1;
      end
      if (sr_take) begin
         sr_tri_ff   <= mrg_tri;
         sr_vis_ff   <= mrg_vis;
         sr_depth_ff <= mrg_depth;
         sr_color_ff <= color_ff[FRONT_STAGES-1];
      end
   end

   carry_type pj_in;

   always_comb begin
      pj_in.vtx   = sr_tri_ff[sr_cnt_ff];
      pj_in.vis   = sr_vis_ff;
      pj_in.depth = sr_depth_ff;
      pj_in.color = sr_color_ff;
      pj_in.last  = (sr_cnt_ff == LAST_V);
   end

   // ---------------- projection and output register
   rsp_item_type pj_out;

   trcp_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .adv       (b_adv),
      .in_valid  (sr_v_ff),
      .in_item   (pj_in),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_item  (pj_out)
   );

   assign rsp_tdata = {pj_out.color, pj_out.depth, pj_out.sy, pj_out.sx,
                       pj_out.vtx.z, pj_out.vtx.y, pj_out.vtx.x};
   assign rsp_tuser = pj_out.vis;
   assign rsp_tlast = pj_out.last;

endmodule

`default_nettype wire

// File: rtl/trcp_checker.sv
// Port-level checks for the triangle block, bound to the top level.
`default_nettype none

module trcp_checker import trcp_pkg::*; (
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire  [OUT_W-1:0]     rsp_tdata,
   input wire  [0:0]           rsp_tuser,
   input wire                  rsp_tlast
);

   localparam int TRI_W = COORD_W + COLOR_W + 1;

   logic             rsp_ok;
   logic             mid_ff;
   logic [TRI_W-1:0] held_ff, cur;

   assign rsp_ok = rsp_tvalid && rsp_tready;
   assign cur    = {rsp_tdata[OUT_W-1 -: COORD_W + COLOR_W], rsp_tuser};

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (rsp_ok) begin
         mid_ff <= !rsp_tlast;
      end
      if (rsp_ok) held_ff <= cur;
   end

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // triangle-wide fields agree across the three results
   a_tri_same: assert property (@(posedge clock) disable iff (reset)
      rsp_ok && mid_ff |-> cur == held_ff)
      else $error("depth, colour or visible differ within a triangle");

   // depth key is the minimum z, so never above this vertex's z
   a_depth_min: assert property (@(posedge clock) disable iff (reset)
      rsp_ok |-> $signed(rsp_tdata[4*COORD_W+2*SCR_W-1 -: COORD_W])
                 <= $signed(rsp_tdata[3*COORD_W-1 -: COORD_W]))
      else $error("depth key above vertex z");

endmodule

bind triangle_rotate_cull_project_top trcp_checker u_trcp_checker (.*);

`default_nettype wire

// File: dv/trcp_checker.sv
// Checker for the triangle block: tracks config, predicts vertex responses, compares.
`default_nettype none

module trcp_scoreboard import trcp_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tready,
   input  wire  [IN_W-1:0]      req_tdata,
   input  wire                  rsp_tvalid,
   input  wire                  rsp_tready,
   input  wire  [OUT_W-1:0]     rsp_tdata,
   input  wire  [0:0]           rsp_tuser,
   input  wire                  rsp_tlast,
   input  wire                  csr_valid,
   input  wire                  csr_ready,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [TRIG_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   pending,
   output int                   vertex_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [COORD_W-1:0] rx, ry, rz;
      logic [SCR_W-1:0]   sx, sy;
      logic               vis;
      logic [COORD_W-1:0] depth;
      logic [COLOR_W-1:0] color;
      logic               last;
   } vertex_rsp_type;

   vertex_rsp_type vertex_q[$];
   longint cp, sp, cy, sy, cr, sr, scr_w, scr_h;

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // exact sum of products, floor shift, clamp to 32 bits
   function automatic longint rotate(longint p, longint cpm, longint q, longint cqm);
      longint v;
      v = (p * cpm + q * cqm) >>> TRIG_FRAC_BITS;
      return sat(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint screen_pos(longint num, longint ctr, longint zabs);
      return sat((num + ctr * zabs) / zabs, -32768, 32767);
   endfunction

   task automatic predict_triangle(input logic [IN_W-1:0] d);
      longint x[3], y[3], z[3];
      longint t, zmin, zabs, focal;
      logic signed [127:0] dx1, dx2, dy1, dy2;
      logic vis, near;
      vertex_rsp_type e;
      focal = 2 * scr_w;
      for (int i = 0; i < 3; i++) begin
         x[i] = longint'(signed'(d[96*i +: 32]));
         y[i] = longint'(signed'(d[96*i+32 +: 32]));
         z[i] = longint'(signed'(d[96*i+64 +: 32]));
         t = y[i];                                   // pitch about x
         y[i] = rotate(t, cp, z[i], -sp);
         z[i] = rotate(t, sp, z[i], cp);
         t = x[i];                                   // yaw about z
         x[i] = rotate(t, cy, y[i], -sy);
         y[i] = rotate(t, sy, y[i], cy);
         t = x[i];                                   // roll about y
         x[i] = rotate(t, cr, z[i], -sr);
         z[i] = rotate(t, sr, z[i], cr);
      end
      near = (z[0] < 0) || (z[1] < 0) || (z[2] < 0);
      dx1 = x[0] - x[1];
      dx2 = x[0] - x[2];
      dy1 = y[0] - y[1];
      dy2 = y[0] - y[2];
      vis = near && (dx1 * dy2 < dy1 * dx2);
      zmin = z[0];
      if (z[1] < zmin) zmin = z[1];
      if (z[2] < zmin) zmin = z[2];
      for (int i = 0; i < 3; i++) begin
         zabs = z[i] < 0 ? -z[i] : z[i];
         if (zabs < (64'sd1 << COORD_FRAC_BITS)) zabs = 64'sd1 << COORD_FRAC_BITS;
         e.rx = x[i][31:0];
         e.ry = y[i][31:0];
         e.rz = z[i][31:0];
         e.sx = 16'(screen_pos(x[i] * focal, scr_w / 2, zabs));
         e.sy = 16'(screen_pos(-y[i] * focal, scr_h / 2, zabs));
         e.vis = vis;
         e.depth = zmin[31:0];
         e.color = d[IN_W-1 -: COLOR_W];
         e.last = (i == 2);
         vertex_q = {vertex_q, e};
      end
   endtask

   always @(posedge clock) begin
      vertex_rsp_type e;
      logic ok;
      if (reset) begin
         vertex_q.delete();
         cp = 16384; sp = 0; cy = 16384; sy = 0; cr = 16384; sr = 0;
         scr_w = 640; scr_h = 480;
         fail_count = 0;
         vertex_count = 0;
      end else begin
         if (req_tvalid && req_tready) predict_triangle(req_tdata);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_COS_PITCH:     cp = longint'(signed'(csr_data));
               REG_SIN_PITCH:     sp = longint'(signed'(csr_data));
               REG_COS_YAW:       cy = longint'(signed'(csr_data));
               REG_SIN_YAW:       sy = longint'(signed'(csr_data));
               REG_COS_ROLL:      cr = longint'(signed'(csr_data));
               REG_SIN_ROLL:      sr = longint'(signed'(csr_data));
               REG_SCREEN_WIDTH:  scr_w = longint'(csr_data[DIM_W-1:0]);
               REG_SCREEN_HEIGHT: scr_h = longint'(csr_data[DIM_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            vertex_count++;
            if (vertex_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with nothing outstanding: %h", $realtime, rsp_tdata);
            end else begin
               e = vertex_q.pop_front();
               ok = (rsp_tdata[31:0] === e.rx) && (rsp_tdata[63:32] === e.ry) &&
                    (rsp_tdata[95:64] === e.rz) && (rsp_tdata[111:96] === e.sx) &&
                    (rsp_tdata[127:112] === e.sy) && (rsp_tdata[159:128] === e.depth) &&
                    (rsp_tdata[183:160] === e.color) && (rsp_tuser[0] === e.vis) &&
                    (rsp_tlast === e.last);
               if (!ok) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: vertex mismatch", $realtime);
                     $display("  exp rot %h %h %h scr %h %h vis %b depth %h col %h last %b",
                              e.rx, e.ry, e.rz, e.sx, e.sy, e.vis, e.depth, e.color, e.last);
                     $display("  got rot %h %h %h scr %h %h vis %b depth %h col %h last %b",
                              rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                              rsp_tdata[111:96], rsp_tdata[127:112], rsp_tuser[0],
                              rsp_tdata[159:128], rsp_tdata[183:160], rsp_tlast);
                  end
               end
            end
         end
      end
      pending = vertex_q.size();
   end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench top: stimulus, handshake pacing and verdict for the triangle block.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import trcp_pkg::*;

   localparam int QUIET_LIMIT = 5000;   // cycles with no handshake at all
   localparam int SETTLE      = 60;     // covers the whole pipe, divider included

   logic                 clock, reset;
   logic                 req_tvalid, req_tready;
   logic [IN_W-1:0]      req_tdata;
   logic                 rsp_tvalid, rsp_tready, rsp_tlast;
   logic [OUT_W-1:0]     rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TRIG_W-1:0]    csr_data;
   int                   fail_count, pending, vertex_count;

   int send_idle_pct = 0;   // chance of an idle cycle before each request
   int rsp_stall_pct = 0;   // chance of rsp_tready low per cycle
   int hold_left     = 0;   // long receiver hold-off, counted down below
   int quiet         = 0;
   int tri_count     = 0;
   int csr_count     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   triangle_rotate_cull_project_top u_top (.*);

   trcp_scoreboard u_chk (.*);

   // receiver pacing; the hold-off counter lives here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog: no request, response or csr write for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [IN_W-1:0] tri_word(int ax, int ay, int az, int bx, int by,
                                                int bz, int cx, int cy, int cz,
                                                logic [COLOR_W-1:0] col);
      return {col, cz, cy, cx, bz, by, bx, az, ay, ax};
   endfunction

   // +-128.0 in x/y, z in front of the viewer: these reach the visible path
   function automatic int near_coord();
      return int'($urandom_range(0, 32'hFFFFFF)) - 32'sh800000;
   endfunction

   function automatic int front_z();
      return -int'($urandom_range(32'h8000, 32'h1FFFFFF));
   endfunction

   function automatic logic [IN_W-1:0] random_triangle();
      logic [IN_W-1:0] d;
      if ($urandom_range(0, 99) < 70)
         d = tri_word(near_coord(), near_coord(), front_z(), near_coord(), near_coord(),
                      front_z(), near_coord(), near_coord(), front_z(),
                      COLOR_W'($urandom));
      else
         d = tri_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, COLOR_W'($urandom));
      return d;
   endfunction

   // one triangle request; ready sampled mid-cycle, so the edge decides
   task automatic send_triangle(input logic [IN_W-1:0] d);
      logic ok;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      tri_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // writes all eight registers, block idle
   task automatic set_config(input int cpv, spv, cyv, syv, crv, srv, wv, hv);
      int vals[8];
      logic ok;
      vals = '{cpv, spv, cyv, syv, crv, srv, wv, hv};
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= TRIG_W'(vals[i]);
         do begin
            @(negedge clock);
            ok = csr_ready;
            @(posedge clock);
         end while (!ok);
         csr_count++;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic int trig();
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_COS_PITCH;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed set under reset config (identity rotation, 640x480)
      send_triangle(tri_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h000000));
      send_triangle(tri_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h7FFFFFFF, 24'hFFFFFF));
      send_triangle(tri_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 24'hA5A5A5));
      // winding one way, then reversed: one is culled as a backface
      send_triangle(tri_word(0, 0, -32'sh50000, 32'sh10000, 0, -32'sh50000,
                             0, 32'sh10000, -32'sh50000, 24'h123456));
      send_triangle(tri_word(0, 0, -32'sh50000, 0, 32'sh10000, -32'sh50000,
                             32'sh10000, 0, -32'sh50000, 24'h654321));
      // all z behind: near-side test fails
      send_triangle(tri_word(0, 0, 32'sh50000, 32'sh10000, 0, 32'sh50000,
                             0, 32'sh10000, 32'sh50000, 24'hFF0000));
      // |z| under 1.0 clamps the divisor; huge x saturates the screen position
      send_triangle(tri_word(32'sh7FFF0000, -32'sh7FFF0000, 32'sh8000, -32'sh100, 32'sh100,
                             -32'sh1, 32'sh10000, 32'sh10000, 0, 24'h00FF00));
      send_triangle(tri_word(32'h80000000, 32'h7FFFFFFF, -32'sh10000, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 1, -1, 32'h7FFFFFFF, 24'h0000FF));
      drain();

      // 45 degree turns on all axes, mid screen
      set_config(11585, 11585, 11585, -11585, 11585, 11585, 800, 600);
      for (int i = 0; i < 8; i++) send_triangle(random_triangle());
      send_triangle(tri_word(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                             32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 24'h0F0F0F));
      drain();

      // random phases, each with its own pacing and register setting
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;  rsp_stall_pct = 0;
               set_config(-16384, 16384, -16384, 16384, -16384, 16384, 4095, 4095);
            end
            1: begin
               send_idle_pct = 58; rsp_stall_pct = 0;
               set_config(16384, -16384, trig(), trig(), trig(), trig(), 1, 1);
            end
            2: begin
               send_idle_pct = 0;  rsp_stall_pct = 58;
               set_config(trig(), trig(), 16384, -16384, trig(), trig(), 0, 0);
            end
            default: begin
               send_idle_pct = 33; rsp_stall_pct = 33;
               set_config(trig(), trig(), trig(), trig(), trig(), trig(),
                          $urandom_range(1, 4095), $urandom_range(1, 4095));
            end
         endcase
         if (ph == 0) begin
            // long receiver hold-off: the front stages fill and stall requests
            hold_left = 300;
            for (int i = 0; i < 30; i++) send_triangle(random_triangle());
            drain();
         end
         for (int i = 0; i < 60; i++) send_triangle(random_triangle());
         drain();
      end

      $display("Covered %0d triangles, %0d vertex responses, %0d register writes,",
               tri_count, vertex_count, csr_count);
      $display("over four pacing modes including a long response hold-off.");
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
